### design/rkc_pkg.sv
// Shared types and constants for the RGB kernel convolution block.
`timescale 1ns / 1ps
package rkc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int COEF_BITS  = 12;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = 27;
    localparam int SCALE_W    = 24;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int CFG_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int TAP_W      = 3;
    localparam int PEND_W     = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

    // Last tap index of the 5x5 window along each axis.
    localparam logic [TAP_W-1:0] TAP_LAST = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             take;
        logic             rd_en;
        logic [TAP_W-1:0] tr;
        logic [TAP_W-1:0] tc;
        logic             mul_en;
        logic [1:0]       mul_ch;
        logic             fin_en;
        logic [1:0]       fin_ch;
        logic             load;
    } rkc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic out_hold;
    } rkc_status_t;

endpackage

### design/rkc_ctrl.sv
// Controller state machine that sequences taps, scaling and output load.
`timescale 1ns / 1ps
module rkc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rkc_pkg::rkc_status_t status,
    output rkc_pkg::rkc_cmd_t    cmd
);
    import rkc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [TAP_W-1:0] tr_reg, tr_next;
    logic [TAP_W-1:0] tc_reg, tc_next;
    logic [1:0]       ch_reg, ch_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        tr_next    = tr_reg;
        tc_next    = tc_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.tr     = tr_reg;
        cmd.tc     = tc_reg;
        cmd.mul_ch = ch_reg;
        cmd.fin_ch = 2'(ch_reg - 2'd1);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                tr_next  = '0;
                tc_next  = '0;
                if (in_valid && status.emit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                if (tc_reg == TAP_LAST)
                begin
                    tc_next = '0;
                    tr_next = 3'(tr_reg + 3'd1);
                    if (tr_reg == TAP_LAST)
                    begin
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    tc_next = 3'(tc_reg + 3'd1);
                end
            end
            ST_WAIT:
            begin
                ch_next    = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = (ch_reg != 2'd3);
                cmd.fin_en = (ch_reg != 2'd0);
                ch_next    = 2'(ch_reg + 2'd1);
                if (ch_reg == 2'd3)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!status.out_hold)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tr_reg    <= '0;
            tc_reg    <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tr_reg    <= tr_next;
            tc_reg    <= tc_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

### design/rkc_datapath.sv
// Datapath: configuration, line store, window accumulation, scaling and output register.
`timescale 1ns / 1ps
module rkc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rkc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rkc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          is_flush,
    input  logic [7:0]                    red_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    blue_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out,
    output logic                          last_of_frame,
    input  rkc_pkg::rkc_cmd_t             cmd,
    output rkc_pkg::rkc_status_t          status
);
    import rkc_pkg::*;

    // Mirror a coordinate back into 0..n-1 (one step of reflection suffices).
    function automatic logic [12:0] mirror(input logic signed [13:0] p,
                                           input logic [12:0] n);
        logic signed [14:0] q;
        logic signed [14:0] pe;
        logic signed [14:0] ne;
        begin
            pe = {p[13], p};
            ne = $signed({2'b00, n});
            q  = pe;
            if (pe < 0)
            begin
                q = -pe - 15'sd1;
            end
            else if (pe >= ne)
            begin
                q = (ne <<< 1) - 15'sd1 - pe;
            end
            return q[12:0];
        end
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]          coef_reg [0:4];
    logic signed [SCALE_W-1:0] scale_reg;
    logic [10:0]               width_reg;
    logic [12:0]               height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= 60'd16777216;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
            scale_reg   <= 24'sd65536;
            width_reg   <= 11'd640;
            height_reg  <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF0:  coef_reg[0] <= cfg_data;
                REG_COEF1:  coef_reg[1] <= cfg_data;
                REG_COEF2:  coef_reg[2] <= cfg_data;
                REG_COEF3:  coef_reg[3] <= cfg_data;
                REG_COEF4:  coef_reg[4] <= cfg_data;
                REG_SCALE:  scale_reg   <= $signed(cfg_data[SCALE_W-1:0]);
                REG_WIDTH:  width_reg   <= cfg_data[10:0];
                REG_HEIGHT: height_reg  <= cfg_data[12:0];
                default:    height_reg  <= height_reg;
            endcase
        end
    end

    // Effective frame size, limited to the supported range.
    logic [10:0] w_eff;
    logic [12:0] h_eff;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg > 11'(MAX_WIDTH))
        begin
            w_eff = 11'(MAX_WIDTH);
        end
        else if (width_reg < 11'd2)
        begin
            w_eff = 11'd2;
        end
        h_eff = height_reg;
        if (height_reg > 13'(MAX_HEIGHT))
        begin
            h_eff = 13'(MAX_HEIGHT);
        end
        else if (height_reg < 13'd2)
        begin
            h_eff = 13'd2;
        end
    end

    // Position counters and pending count.
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [SLOT_W-1:0] in_slot_reg, out_slot_reg;
    logic [PEND_W-1:0] pending_reg;

    logic [ROW_W-1:0] in_row_g, out_row_g;
    logic [COL_W-1:0] in_col_g, out_col_g;
    logic             in_col_end, in_row_end, out_col_end, out_row_end;
    logic             pixel_take;

    always_comb
    begin
        in_row_g   = ({1'b0, in_row_reg} >= h_eff) ? '0 : in_row_reg;
        out_row_g  = ({1'b0, out_row_reg} >= h_eff) ? '0 : out_row_reg;
        in_col_g   = ({1'b0, in_col_reg} >= w_eff) ? '0 : in_col_reg;
        out_col_g  = ({1'b0, out_col_reg} >= w_eff) ? '0 : out_col_reg;
        in_col_end = ({1'b0, in_col_g} + 11'd1) >= w_eff;
        in_row_end = ({1'b0, in_row_g} + 13'd1) >= h_eff;
        out_col_end = ({1'b0, out_col_reg} + 11'd1) >= w_eff;
        out_row_end = ({1'b0, out_row_reg} + 13'd1) >= h_eff;
        pixel_take = cmd.take && !is_flush;
    end

    // An output is due when the window is complete, or on a flush with work pending.
    logic [12:0] thresh;
    assign thresh = {1'b0, w_eff, 1'b0} + 13'd3;

    always_comb
    begin
        if (is_flush)
        begin
            status.emit = (pending_reg != '0);
        end
        else
        begin
            status.emit = ({1'b0, pending_reg} + 13'd1) >= thresh;
        end
        status.out_hold = out_valid && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                out_row_reg <= out_row_g;
                out_col_reg <= out_col_g;
                if (pixel_take)
                begin
                    if (in_col_end)
                    begin
                        in_col_reg  <= '0;
                        in_slot_reg <= 3'(in_slot_reg + 3'd1);
                        in_row_reg  <= in_row_end ? '0 : 12'(in_row_g + 12'd1);
                    end
                    else
                    begin
                        in_row_reg <= in_row_g;
                        in_col_reg <= 10'(in_col_g + 10'd1);
                    end
                end
                else
                begin
                    in_row_reg <= in_row_g;
                    in_col_reg <= in_col_g;
                end
                pending_reg <= 12'(pending_reg + {11'd0, !is_flush}
                                   - {11'd0, status.emit});
            end
            if (cmd.load)
            begin
                if (out_col_end)
                begin
                    out_col_reg  <= '0;
                    out_slot_reg <= 3'(out_slot_reg + 3'd1);
                    out_row_reg  <= out_row_end ? '0 : 12'(out_row_reg + 12'd1);
                end
                else
                begin
                    out_col_reg <= 10'(out_col_reg + 10'd1);
                end
            end
        end
    end

    // Tap address: mirrored row selects the line slot, mirrored column the entry.
    logic [12:0]       tap_x, tap_y;
    logic [SLOT_W-1:0] tap_slot;
    logic [ADDR_W-1:0] rd_addr;

    always_comb
    begin
        tap_x = mirror($signed({2'b00, out_row_reg}) + $signed({11'd0, cmd.tr}) - 14'sd2,
                       h_eff);
        tap_y = mirror($signed({4'd0, out_col_reg}) + $signed({11'd0, cmd.tc}) - 14'sd2,
                       {2'b00, w_eff});
        tap_slot = 3'(out_slot_reg + tap_x[2:0] - out_row_reg[2:0]);
        rd_addr  = {tap_slot, tap_y[COL_W-1:0]};
    end

    // Line store: eight row slots, written on each pixel, read one tap a cycle.
    logic [23:0] line_mem [0:(1 << ADDR_W) - 1];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            line_mem[{in_slot_reg, in_col_g}] <= {red_in, green_in, blue_in};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    // Tap delay alongside the memory read.
    logic             mac_valid_reg;
    logic [TAP_W-1:0] tr_d_reg, tc_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_valid_reg <= 1'b0;
        end
        else
        begin
            mac_valid_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_d_reg <= cmd.tr;
        tc_d_reg <= cmd.tc;
    end

    // Multiply-accumulate of one tap for all three channels.
    logic [CFG_W-1:0]            coef_row_sel;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [20:0]          term_r, term_g, term_b;
    logic signed [SUM_W-1:0]     sum_r_reg, sum_g_reg, sum_b_reg;

    always_comb
    begin
        coef_row_sel = coef_reg[tr_d_reg];
        coef   = $signed(coef_row_sel[tc_d_reg * COEF_BITS +: COEF_BITS]);
        term_r = coef * $signed({1'b0, rd_data_reg[23:16]});
        term_g = coef * $signed({1'b0, rd_data_reg[15:8]});
        term_b = coef * $signed({1'b0, rd_data_reg[7:0]});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (mac_valid_reg)
        begin
            sum_r_reg <= sum_r_reg + term_r;
            sum_g_reg <= sum_g_reg + term_g;
            sum_b_reg <= sum_b_reg + term_b;
        end
    end

    // Scaling: one channel a cycle through a shared multiplier.
    logic signed [SUM_W-1:0]  sum_sel;
    logic signed [PROD_W-1:0] prod_c, prod_reg;

    always_comb
    begin
        unique case (cmd.mul_ch)
            2'd0:    sum_sel = sum_r_reg;
            2'd1:    sum_sel = sum_g_reg;
            default: sum_sel = sum_b_reg;
        endcase
        prod_c = sum_sel * scale_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_c;
        end
    end

    // Floor by the fraction shift and clamp to 0..255.
    logic signed [PROD_W-FRAC_BITS-1:0] quot;
    logic [7:0]                         clamped;
    logic [7:0]                         res_reg [0:2];

    always_comb
    begin
        quot = prod_reg[PROD_W-1:FRAC_BITS];
        if (quot < 0)
        begin
            clamped = 8'd0;
        end
        else if (quot > 255)
        begin
            clamped = 8'd255;
        end
        else
        begin
            clamped = quot[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            res_reg[cmd.fin_ch] <= clamped;
        end
    end

    // Output register; holds a transaction until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            red_out       <= res_reg[0];
            green_out     <= res_reg[1];
            blue_out      <= res_reg[2];
            last_of_frame <= out_col_end && out_row_end;
        end
    end

endmodule

### design/rgb_kernel_convolution_top.sv
// Top level of the RGB 5x5 kernel convolution block.
`timescale 1ns / 1ps
// Usage: RGB pixels enter on the input channel (in_valid / in_stall) in raster
// order; filtered pixels leave on the output channel (out_valid / out_stall).
// An input transaction with is_flush set carries no pixel and drains one
// pending output pixel. Registers are written through cfg_we / cfg_index /
// cfg_data while the block is idle.
// Throughput: input pixels that complete no window are taken one per cycle. An
// input that produces an output holds off the input side: the 25 window taps
// are read one per cycle from the line store, then the three channel sums
// share one scaling multiplier in turn, then the output loads.
// Outputs trail inputs by two rows plus two pixels; flushes drain the rest.
// Reset clears the counters and the output valid and loads the identity
// kernel, scale 1.0 and a 640x480 frame; the line store is not cleared and
// holds nothing meaningful until written.
// While the receiver stalls, the finished transaction stays in the output
// register; the block still takes inputs and waits only when the next
// output is ready to load.
module rgb_kernel_convolution_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rkc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rkc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          is_flush,
    input  logic [7:0]                    red_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    blue_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out,
    output logic                          last_of_frame
);
    import rkc_pkg::*;

    rkc_cmd_t    cmd;
    rkc_status_t status;

    // Sequencer.
    rkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    rkc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .is_flush      (is_flush),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .last_of_frame (last_of_frame),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

### design/rkc_checker.sv
// Port-level checker for the convolution block and its bind statement.
`timescale 1ns / 1ps
module rkc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out
);

    // A stalled output transaction stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A stalled output transaction keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out))
        else $error("output data changed while stalled");

    // The block only goes busy after taking an input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall raised without an input transaction");

    // A new output is produced only while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output appeared without a computation in progress");

endmodule

bind rgb_kernel_convolution_top rkc_checker u_rkc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out)
);
